// ----- rtl/core/ttcq_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttcq_pkg
// shared types and constants for the glyph outline to quadratic curve block
// ----------------------------------------------------------------------------
package ttcq_pkg;

  localparam int COORD_W  = 16;
  localparam int HALF_W   = 17;
  localparam int QUEUE_D  = 3;

  // flag byte bit positions
  localparam int FLAG_ON_CURVE_BIT = 0;
  localparam int FLAG_SHORT_X_BIT  = 1;
  localparam int FLAG_SHORT_Y_BIT  = 2;
  localparam int FLAG_SAME_X_BIT   = 4;
  localparam int FLAG_SAME_Y_BIT   = 5;

  // contour phase codes
  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_START = 2'd1;
  localparam logic [1:0] PH_PIVOT = 2'd2;

  typedef struct packed {
    logic [HALF_W-1:0] start_x;
    logic [HALF_W-1:0] start_y;
    logic [HALF_W-1:0] ctrl_x;
    logic [HALF_W-1:0] ctrl_y;
    logic [HALF_W-1:0] end_x;
    logic [HALF_W-1:0] end_y;
    logic              closing;
    logic              last;
  } curve_t;

  typedef struct packed {
    logic [1:0]         phase;
    logic [HALF_W-1:0]  qs_x;
    logic [HALF_W-1:0]  qs_y;
    logic [COORD_W-1:0] piv_x;
    logic [COORD_W-1:0] piv_y;
    logic [COORD_W-1:0] first_x;
    logic [COORD_W-1:0] first_y;
  } outline_st_t;

  typedef struct packed {
    outline_st_t st;
    logic        emit;
    curve_t      curve;
  } feed_res_t;

endpackage

// ----- rtl/core/truetype_contour_to_quad_curves.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// truetype_contour_to_quad_curves
// turns decoded glyph outline points into quadratic curves in half units
// ----------------------------------------------------------------------------
//
// channel | dir | payload                                   | marks
// --------+-----+-------------------------------------------+-----------------------
// in_     | in  | point_flags, x_data, y_data (40 bits)     | tuser glyph_start,
//         |     |                                           | tlast contour_end
// out_    | out | start/ctrl/end x,y, 17-bit signed (104 b) | tuser closing_curve,
//         |     |                                           | tlast last_of_item
//
// - a point is held in an input register, decoded and turned into its curves
//   combinationally, and the curves go into a three-deep result queue
// - a result passes the input register and then the result queue; while the output
//   is ready, a point that makes at most one curve can follow every cycle, and a
//   closing point with two curves holds up the next point, set by the one-wide output port
// - the input side keeps accepting while up to one result waits in the queue
// - rst_n is synchronous: phase, coordinates and queue fill go to zero
module truetype_contour_to_quad_curves (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [39:0]  in_tdata,   // point_flags[7:0], x_data[23:8], y_data[39:24]
  input  logic         in_tuser,   // glyph_start
  input  logic         in_tlast,   // contour_end
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [103:0] out_tdata,  // start_x, start_y, ctrl_x, ctrl_y, end_x, end_y, pad
  output logic         out_tuser,  // closing_curve
  output logic         out_tlast   // last_of_item
);

  localparam int CW = ttcq_pkg::COORD_W;
  localparam int HW = ttcq_pkg::HALF_W;
  localparam int QD = ttcq_pkg::QUEUE_D;

  // input register
  logic          stv_r;
  logic [7:0]    st_flags_r;
  logic [CW-1:0] st_xd_r;
  logic [CW-1:0] st_yd_r;
  logic          st_gs_r;
  logic          st_ce_r;

  // outline state
  ttcq_pkg::outline_st_t ost_r, ost_nxt;
  logic [CW-1:0] prev_x_r, prev_x_nxt;
  logic [CW-1:0] prev_y_r, prev_y_nxt;

  // result queue, head at entry 0
  ttcq_pkg::curve_t q_r [QD];
  ttcq_pkg::curve_t q_nxt [QD];
  logic [1:0]    cnt_r, cnt_nxt;

  logic          in_acc;
  logic          take;
  logic          pop;
  logic [1:0]    base;
  logic [1:0]    n_res;
  ttcq_pkg::curve_t r0, r1;
  ttcq_pkg::outline_st_t s0;
  ttcq_pkg::feed_res_t f1, f2;
  logic [CW-1:0] px0, py0, nx, ny;

  // coordinate update: short byte with sign, long delta, or repeat
  function automatic logic [CW-1:0] next_coord(input logic is_short, input logic same,
                                               input logic [CW-1:0] prev,
                                               input logic [CW-1:0] data);
    logic [CW-1:0] b;
    b = {{(CW-8){1'b0}}, data[7:0]};
    if (is_short) begin
      next_coord = same ? prev + b : prev - b;
    end else begin
      next_coord = same ? prev : prev + data;
    end
  endfunction

  // one point into the curve builder
  function automatic ttcq_pkg::feed_res_t feed(input ttcq_pkg::outline_st_t s,
                                               input logic [CW-1:0] x,
                                               input logic [CW-1:0] y,
                                               input logic on, input logic closing);
    ttcq_pkg::feed_res_t r;
    logic [HW-1:0] hx, hy, ix, iy, px2, py2;
    logic [HW:0]   sumx, sumy;
    hx   = {x, 1'b0};
    hy   = {y, 1'b0};
    px2  = {s.piv_x, 1'b0};
    py2  = {s.piv_y, 1'b0};
    ix   = {s.piv_x[CW-1], s.piv_x} + {x[CW-1], x};
    iy   = {s.piv_y[CW-1], s.piv_y} + {y[CW-1], y};
    sumx = {s.qs_x[HW-1], s.qs_x} + {hx[HW-1], hx};
    sumy = {s.qs_y[HW-1], s.qs_y} + {hy[HW-1], hy};
    r = '0;
    r.st            = s;
    r.curve.start_x = s.qs_x;
    r.curve.start_y = s.qs_y;
    r.curve.ctrl_x  = px2;
    r.curve.ctrl_y  = py2;
    r.curve.end_x   = hx;
    r.curve.end_y   = hy;
    r.curve.closing = closing;
    r.curve.last    = 1'b0;
    case (s.phase)
      ttcq_pkg::PH_START: begin
        if (on) begin
          // line as a curve: control at the midpoint, start is always even here
          r.emit         = 1'b1;
          r.curve.ctrl_x = sumx[HW:1];
          r.curve.ctrl_y = sumy[HW:1];
          r.st.qs_x      = hx;
          r.st.qs_y      = hy;
        end else begin
          r.st.piv_x = x;
          r.st.piv_y = y;
          r.st.phase = ttcq_pkg::PH_PIVOT;
        end
      end
      ttcq_pkg::PH_PIVOT: begin
        r.emit = 1'b1;
        if (on) begin
          r.st.qs_x  = hx;
          r.st.qs_y  = hy;
          r.st.phase = ttcq_pkg::PH_START;
        end else begin
          // two off-curve points in a row: implied on-curve midpoint
          r.curve.end_x = ix;
          r.curve.end_y = iy;
          r.st.qs_x     = ix;
          r.st.qs_y     = iy;
          r.st.piv_x    = x;
          r.st.piv_y    = y;
        end
      end
      default: begin
        // contour start, an off-curve first point counts as on-curve
        r.st.qs_x    = hx;
        r.st.qs_y    = hy;
        r.st.first_x = x;
        r.st.first_y = y;
        r.st.phase   = ttcq_pkg::PH_START;
      end
    endcase
    feed = r;
  endfunction

  assign in_acc    = in_tvalid && in_tready;
  assign take      = stv_r && (cnt_r <= 2'd1);
  assign in_tready = !stv_r || take;
  assign pop       = out_tvalid && out_tready;

  // decode and curve building for the held point
  always_comb begin
    s0  = ost_r;
    px0 = prev_x_r;
    py0 = prev_y_r;
    if (s0.phase != ttcq_pkg::PH_START && s0.phase != ttcq_pkg::PH_PIVOT) begin
      s0.phase = ttcq_pkg::PH_IDLE;
    end
    if (st_gs_r) begin
      // glyph start drops any open contour
      px0      = '0;
      py0      = '0;
      s0.phase = ttcq_pkg::PH_IDLE;
    end
    nx = next_coord(st_flags_r[ttcq_pkg::FLAG_SHORT_X_BIT],
                    st_flags_r[ttcq_pkg::FLAG_SAME_X_BIT], px0, st_xd_r);
    ny = next_coord(st_flags_r[ttcq_pkg::FLAG_SHORT_Y_BIT],
                    st_flags_r[ttcq_pkg::FLAG_SAME_Y_BIT], py0, st_yd_r);
    f1 = feed(s0, nx, ny, st_flags_r[ttcq_pkg::FLAG_ON_CURVE_BIT], 1'b0);
    // closing curve back to the first point
    f2 = feed(f1.st, f1.st.first_x, f1.st.first_y, 1'b1, 1'b1);

    ost_nxt    = ost_r;
    prev_x_nxt = prev_x_r;
    prev_y_nxt = prev_y_r;
    if (take) begin
      prev_x_nxt = nx;
      prev_y_nxt = ny;
      if (st_ce_r) begin
        ost_nxt       = f2.st;
        ost_nxt.phase = ttcq_pkg::PH_IDLE;
      end else begin
        ost_nxt = f1.st;
      end
    end

    // pack the results of this point, first curve first
    if (f1.emit) begin
      r0    = f1.curve;
      r1    = f2.curve;
      n_res = (st_ce_r && f2.emit) ? 2'd2 : 2'd1;
    end else begin
      r0    = f2.curve;
      r1    = f2.curve;
      n_res = (st_ce_r && f2.emit) ? 2'd1 : 2'd0;
    end
    if (n_res == 2'd2) begin
      r1.last = 1'b1;
    end else begin
      r0.last = 1'b1;
    end
  end

  // result queue: shift on pop, append behind the remaining entries
  always_comb begin
    base = cnt_r - {1'b0, pop};
    for (int i = 0; i < QD; i++) begin
      if (pop && i < QD - 1) begin
        q_nxt[i] = q_r[i + 1];
      end else begin
        q_nxt[i] = q_r[i];
      end
      if (take && n_res != 2'd0 && 2'(i) == base) begin
        q_nxt[i] = r0;
      end
      if (take && n_res == 2'd2 && 2'(i) == base + 2'd1) begin
        q_nxt[i] = r1;
      end
    end
    cnt_nxt = cnt_r - {1'b0, pop} + (take ? n_res : 2'd0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stv_r    <= 1'b0;
      cnt_r    <= '0;
      ost_r    <= '0;
      prev_x_r <= '0;
      prev_y_r <= '0;
    end else begin
      if (in_acc) begin
        stv_r <= 1'b1;
      end else if (take) begin
        stv_r <= 1'b0;
      end
      cnt_r    <= cnt_nxt;
      ost_r    <= ost_nxt;
      prev_x_r <= prev_x_nxt;
      prev_y_r <= prev_y_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      st_flags_r <= in_tdata[7:0];
      st_xd_r    <= in_tdata[23:8];
      st_yd_r    <= in_tdata[39:24];
      st_gs_r    <= in_tuser;
      st_ce_r    <= in_tlast;
    end
    for (int i = 0; i < QD; i++) begin
      q_r[i] <= q_nxt[i];
    end
  end

  assign out_tvalid = (cnt_r != 2'd0);
  assign out_tdata  = {2'b00, q_r[0].end_y, q_r[0].end_x, q_r[0].ctrl_y,
                       q_r[0].ctrl_x, q_r[0].start_y, q_r[0].start_x};
  assign out_tuser  = q_r[0].closing;
  assign out_tlast  = q_r[0].last;

  // unused phase code never held
  a_phase_legal: assert property (@(posedge clk) disable iff (!rst_n)
    ost_r.phase != 2'd3)
    else $error("phase register holds unused code");

  // a closing curve is always the final curve of its point
  a_close_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tlast)
    else $error("closing curve not marked last");

  // contour end leaves the builder awaiting a new contour
  a_end_idle: assert property (@(posedge clk) disable iff (!rst_n)
    take && st_ce_r |=> ost_r.phase == ttcq_pkg::PH_IDLE)
    else $error("phase not cleared after contour end");

  // queue fill only moves on a push or a pop
  a_cnt_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !take && !pop |=> $stable(cnt_r))
    else $error("queue count changed without transaction");

  // queue never overfills
  a_cnt_max: assert property (@(posedge clk) disable iff (!rst_n)
    take |-> cnt_r <= 2'd1)
    else $error("point taken without room for two curves");

endmodule
